FILE: sv/key_autorepeat_and_direction_tracker_defines.svh
// Assertion helpers shared by the RTL; all sample on i_clk and idle in reset.
`ifndef KEY_AUTOREPEAT_AND_DIRECTION_TRACKER_DEFINES_SVH
`define KEY_AUTOREPEAT_AND_DIRECTION_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define KADT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KADT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/kadt_pkg.sv
`timescale 1ns / 1ps
package kadt_pkg;

    localparam int CODE_W  = 9;
    localparam int COUNT_W = 9;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_REPEAT_DELAY  = 3'd0,
        CFG_REPEAT_PERIOD = 3'd1,
        CFG_DOWN_KEY      = 3'd2,
        CFG_LEFT_KEY      = 3'd3,
        CFG_RIGHT_KEY     = 3'd4,
        CFG_UP_KEY        = 3'd5
    } t_cfg_idx;

    localparam logic [7:0]        RST_REPEAT_DELAY  = 8'd23;
    localparam logic [7:0]        RST_REPEAT_PERIOD = 8'd6;
    localparam logic [CODE_W-1:0] RST_DOWN_KEY      = 9'd81;
    localparam logic [CODE_W-1:0] RST_LEFT_KEY      = 9'd80;
    localparam logic [CODE_W-1:0] RST_RIGHT_KEY     = 9'd79;
    localparam logic [CODE_W-1:0] RST_UP_KEY        = 9'd82;

    // Direction codes (numpad style)
    localparam logic [3:0] DIR_NONE  = 4'd0;
    localparam logic [3:0] DIR_DOWN  = 4'd2;
    localparam logic [3:0] DIR_LEFT  = 4'd4;
    localparam logic [3:0] DIR_RIGHT = 4'd6;
    localparam logic [3:0] DIR_UP    = 4'd8;

    // Arrow bit i -> straight direction code
    localparam logic [3:0] DIR_CODE [4] = '{DIR_DOWN, DIR_LEFT, DIR_RIGHT, DIR_UP};

    // Priority of the other arrows, per arrow
    localparam logic [1:0] ORDER_TAB [4][3] = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd3, 2'd1},
        '{2'd1, 2'd2, 2'd0}
    };

    // Combined code for a pair of arrows
    localparam logic [3:0] COMBO_TAB [4][4] = '{
        '{4'd2, 4'd1, 4'd3, 4'd0},
        '{4'd1, 4'd4, 4'd0, 4'd7},
        '{4'd3, 4'd0, 4'd6, 4'd9},
        '{4'd0, 4'd7, 4'd9, 4'd8}
    };

    typedef struct packed {
        logic               level;
        logic [COUNT_W-1:0] count;
    } t_key_entry;

    typedef struct packed {
        logic [3:0] four;
        logic [3:0] eight;
    } t_dirs;

    typedef struct packed {
        logic [3:0] dir;
        logic [3:0] last;
    } t_four_res;

    function automatic t_four_res resolve_four(input logic [3:0] lv, input logic [3:0] last);
        t_four_res  res;
        logic       done;
        logic [1:0] p;
        logic [1:0] o;
        res.dir  = DIR_NONE;
        res.last = last;
        done     = 1'b0;
        p        = 2'd0;
        o        = 2'd0;
        // opposite pair alone: no direction, memory kept
        if (lv == 4'h9 || lv == 4'h6) begin
            done = 1'b1;
        end
        if (!done && (last == DIR_DOWN || last == DIR_LEFT ||
                      last == DIR_RIGHT || last == DIR_UP)) begin
            p = 2'(last[3:1] - 3'd1);
            if (lv[p]) begin
                for (int j = 0; j < 3; j++) begin
                    o = ORDER_TAB[p][j];
                    if (!done && lv[o]) begin
                        res.dir = DIR_CODE[o];
                        done    = 1'b1;
                    end
                end
            end
        end
        if (!done) begin
            for (int i = 0; i < 4; i++) begin
                if (!done && lv[2'(i)]) begin
                    res.dir  = DIR_CODE[2'(i)];
                    res.last = DIR_CODE[2'(i)];
                    done     = 1'b1;
                end
            end
            if (!done) begin
                res.last = DIR_NONE;
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] resolve_eight(input logic [3:0] lv);
        logic [3:0] res;
        logic       done;
        logic       inner;
        logic [1:0] o;
        res  = DIR_NONE;
        done = 1'b0;
        o    = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (!done && lv[2'(i)]) begin
                inner = 1'b0;
                for (int j = 0; j < 3; j++) begin
                    o = ORDER_TAB[2'(i)][j];
                    if (!inner && lv[o]) begin
                        res   = COMBO_TAB[2'(i)][o];
                        inner = 1'b1;
                    end
                end
                if (!inner) begin
                    res = DIR_CODE[2'(i)];
                end
                done = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/key_autorepeat_and_direction_tracker.sv
`timescale 1ns / 1ps
// Key auto-repeat and arrow direction tracker.
// Input stream (s_axis): one sampled key per word; tdata carries the scancode
// and level, tlast marks the last key of a scan frame. Output stream (m_axis):
// one word per input word with held / triggered / repeated flags for that key
// and the four-way and eight-way arrow directions as of the latest frame end.
// Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 delay, 1 period, 2..5 down/left/right/up scancodes); write only when idle.
// Throughput: one word per cycle when m_axis is not stalled and no clear runs.
// Path: key RAM read into the update stage register, then the result register.
// The per-key state is one read-modify-write on a single-port-write RAM;
// back-to-back words for the same key are forwarded around the RAM.
// Reset: after i_rst_n is released the key RAM is swept to zero with
// s_axis_tready low; config writes are still taken then.
// Stall: m_axis holds its word until taken; one word waits in the update
// stage, and s_axis_tready drops only when both are full and m_axis is stalled.
module key_autorepeat_and_direction_tracker #(
    parameter int NUM_KEYS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] key_code, [9] key_down, zero pad
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] held, [1] triggered, [2] repeated,
                                        // [6:3] dir_four, [10:7] dir_eight, zero pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata
);
    import kadt_pkg::*;
    `include "key_autorepeat_and_direction_tracker_defines.svh"

    localparam int AW = $clog2(NUM_KEYS);

    // config registers
    logic [7:0]                  r_repeat_delay;
    logic [7:0]                  r_repeat_period;
    logic [3:0][CODE_W-1:0]      r_arrow_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= RST_REPEAT_DELAY;
            r_repeat_period <= RST_REPEAT_PERIOD;
            r_arrow_key[0]  <= RST_DOWN_KEY;
            r_arrow_key[1]  <= RST_LEFT_KEY;
            r_arrow_key[2]  <= RST_RIGHT_KEY;
            r_arrow_key[3]  <= RST_UP_KEY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg_wdata[7:0];
                CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_wdata[7:0];
                CFG_DOWN_KEY:      r_arrow_key[0]  <= i_cfg_wdata;
                CFG_LEFT_KEY:      r_arrow_key[1]  <= i_cfg_wdata;
                CFG_RIGHT_KEY:     r_arrow_key[2]  <= i_cfg_wdata;
                CFG_UP_KEY:        r_arrow_key[3]  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input word fields
    logic [CODE_W-1:0] in_code;
    logic              in_down;
    logic              in_accept;
    logic              busy;

    assign in_code   = s_axis_tdata[CODE_W-1:0];
    assign in_down   = s_axis_tdata[CODE_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // update stage (RAM data arrives here)
    logic              r_s1_valid;
    logic [CODE_W-1:0] r_s1_code;
    logic              r_s1_down;
    logic              r_s1_fend;
    logic              r_s1_inrange;
    logic              s1_adv;

    // result register
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !busy && (!r_s1_valid || s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_code    <= in_code;
            r_s1_down    <= in_down;
            r_s1_fend    <= s_axis_tlast;
            r_s1_inrange <= (11'(in_code) < 11'(NUM_KEYS));
        end
    end

    // per-key state
    t_key_entry ent;
    t_key_entry ent_wr;
    logic       key_wr;

    kadt_key_store #(
        .NUM_KEYS (NUM_KEYS),
        .AW       (AW)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (AW'(in_code)),
        .i_wr_en   (key_wr),
        .i_wr_addr (AW'(r_s1_code)),
        .i_wr_data (ent_wr),
        .o_rd_data (ent),
        .o_busy    (busy)
    );

    // typematic count: delay below 2 acts as 2, period 0 acts as 1
    logic [7:0]  eff_delay;
    logic [7:0]  eff_period;
    logic [9:0]  cnt_inc;
    logic [9:0]  cnt_lim;
    logic [8:0]  cnt_new;
    logic        res_held;
    logic        res_trig;
    logic        res_rep;

    always_comb begin
        eff_delay  = (r_repeat_delay < 8'd2) ? 8'd2 : r_repeat_delay;
        eff_period = (r_repeat_period == 8'd0) ? 8'd1 : r_repeat_period;
        cnt_inc    = 10'(ent.count) + 10'd1;
        cnt_lim    = 10'(eff_delay) + 10'(eff_period);
        // fold back by one period so the count stays bounded
        cnt_new    = (cnt_inc >= cnt_lim) ? 9'(eff_delay) : cnt_inc[8:0];
        res_held   = r_s1_inrange && r_s1_down;
        res_trig   = res_held && !ent.level;
        res_rep    = res_held && (cnt_new == 9'd1 || cnt_new == 9'(eff_delay));
        ent_wr.level = r_s1_down;
        ent_wr.count = r_s1_down ? cnt_new : '0;
        key_wr     = s1_adv && r_s1_inrange;
    end

    // arrow levels and direction resolvers
    t_dirs dirs;

    kadt_dir_tracker u_dir_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_adv),
        .i_code      (r_s1_code),
        .i_down      (r_s1_down),
        .i_frame_end (r_s1_fend),
        .i_arrow_key (r_arrow_key),
        .o_dirs      (dirs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {5'd0, dirs.eight, dirs.four, res_rep, res_trig, res_held};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `KADT_ASSERT_NOW(a_no_accept_in_clear, busy, !s_axis_tready,
        "word accepted during key RAM clear")
    `KADT_ASSERT_NOW(a_flags_need_held, m_axis_tvalid,
        m_axis_tdata[0] || (!m_axis_tdata[1] && !m_axis_tdata[2]),
        "trigger or repeat without held")
    `KADT_ASSERT_NOW(a_four_way_code, m_axis_tvalid,
        !m_axis_tdata[3] && (m_axis_tdata[6:3] <= 4'd8),
        "illegal four-way direction")
    `KADT_ASSERT_NEXT(a_update_lands, s1_adv, r_out_valid,
        "updated word not in result register")

endmodule

FILE: sv/kadt_key_store.sv
`timescale 1ns / 1ps
module kadt_key_store #(
    parameter int NUM_KEYS = 512,
    parameter int AW       = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  kadt_pkg::t_key_entry i_wr_data,
    output kadt_pkg::t_key_entry o_rd_data,
    output logic                o_busy
);
    import kadt_pkg::*;

    t_key_entry r_mem [NUM_KEYS];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_key_entry    mem_wd;

    t_key_entry r_rd_data;
    t_key_entry r_fwd_data;
    logic       r_fwd_hit;

    // clearing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(NUM_KEYS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        mem_we = r_clr_busy || i_wr_en;
        mem_wa = r_clr_busy ? r_clr_idx : i_wr_addr;
        mem_wd = r_clr_busy ? t_key_entry'('0) : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // read-first RAM; a write to the same key in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

FILE: sv/kadt_dir_tracker.sv
`timescale 1ns / 1ps
module kadt_dir_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [kadt_pkg::CODE_W-1:0]    i_code,
    input  logic                           i_down,
    input  logic                           i_frame_end,
    input  logic [3:0][kadt_pkg::CODE_W-1:0] i_arrow_key,
    output kadt_pkg::t_dirs                o_dirs
);
    import kadt_pkg::*;

    logic [3:0] r_arrow_lv;
    logic [3:0] r_last_dir;
    logic [3:0] r_four;
    logic [3:0] r_eight;

    logic [3:0] n_arrow_lv;
    logic [3:0] n_last_dir;
    logic [3:0] n_four;
    logic [3:0] n_eight;
    t_four_res  four_res;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_arrow_lv[i] = (i_code == i_arrow_key[i]) ? i_down : r_arrow_lv[i];
        end
        four_res   = resolve_four(n_arrow_lv, r_last_dir);
        n_four     = i_frame_end ? four_res.dir : r_four;
        n_last_dir = i_frame_end ? four_res.last : r_last_dir;
        n_eight    = i_frame_end ? resolve_eight(n_arrow_lv) : r_eight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrow_lv <= '0;
            r_last_dir <= DIR_NONE;
            r_four     <= DIR_NONE;
            r_eight    <= DIR_NONE;
        end else if (i_en) begin
            r_arrow_lv <= n_arrow_lv;
            r_last_dir <= n_last_dir;
            r_four     <= n_four;
            r_eight    <= n_eight;
        end
    end

    // values the current word reports
    assign o_dirs.four  = n_four;
    assign o_dirs.eight = n_eight;

endmodule

FILE: test/key_autorepeat_and_direction_tracker_test.sv
`timescale 1ns / 1ps
module key_autorepeat_and_direction_tracker_test;
    import kadt_pkg::*;

    // Other arrows in priority order, per arrow (bit 0 down, 1 left, 2 right, 3 up)
    localparam logic [1:0] NEXT_PICK [4][3] = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd3, 2'd1},
        '{2'd1, 2'd2, 2'd0}
    };

    // Numpad code for an arrow held together with another
    localparam logic [3:0] PAIR_CODE [4][4] = '{
        '{4'd2, 4'd1, 4'd3, 4'd0},
        '{4'd1, 4'd4, 4'd0, 4'd7},
        '{4'd3, 4'd0, 4'd6, 4'd9},
        '{4'd0, 4'd7, 4'd9, 4'd8}
    };

    // One result word, highest bits first
    typedef struct packed {
        logic [3:0] eight;
        logic [3:0] four;
        logic       rep;
        logic       trig;
        logic       held;
    } t_key_flags;

    // Tracks per-key levels, held counts and arrow state; predicts and checks
    // every result word in order.
    class t_key_tracker;
        logic [9:0] key_mem [512];      // {last level, held count}
        logic [3:0] arrows_down;
        logic [3:0] remembered_dir;
        logic [3:0] four_now;
        logic [3:0] eight_now;
        logic [7:0] delay_reg;
        logic [7:0] period_reg;
        logic [8:0] arrow_code [4];
        t_key_flags flags_due [$];
        int         error_count;

        function new();
            error_count = 0;
            clear();
        endfunction

        function void clear();
            foreach (key_mem[i]) key_mem[i] = '0;
            arrows_down    = '0;
            remembered_dir = DIR_NONE;
            four_now       = DIR_NONE;
            eight_now      = DIR_NONE;
            delay_reg      = RST_REPEAT_DELAY;
            period_reg     = RST_REPEAT_PERIOD;
            arrow_code[0]  = RST_DOWN_KEY;
            arrow_code[1]  = RST_LEFT_KEY;
            arrow_code[2]  = RST_RIGHT_KEY;
            arrow_code[3]  = RST_UP_KEY;
            flags_due.delete();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [8:0] val);
            case (idx)
                CFG_REPEAT_DELAY:  delay_reg     = val[7:0];
                CFG_REPEAT_PERIOD: period_reg    = val[7:0];
                CFG_DOWN_KEY:      arrow_code[0] = val;
                CFG_LEFT_KEY:      arrow_code[1] = val;
                CFG_RIGHT_KEY:     arrow_code[2] = val;
                CFG_UP_KEY:        arrow_code[3] = val;
                default: ;
            endcase
        endfunction

        function logic [3:0] arrow_dir(int i);
            return 4'(2 * i + 2);
        endfunction

        function logic [3:0] pick_four(logic [3:0] lv);
            logic [1:0] p;
            // exactly one opposite pair: nothing, memory untouched
            if (lv == 4'b1001 || lv == 4'b0110) return DIR_NONE;
            if (remembered_dir == DIR_DOWN || remembered_dir == DIR_LEFT ||
                remembered_dir == DIR_RIGHT || remembered_dir == DIR_UP) begin
                p = 2'(remembered_dir / 2 - 1);
                if (lv[p]) begin
                    for (int j = 0; j < 3; j++) begin
                        if (lv[NEXT_PICK[p][j]]) return arrow_dir(NEXT_PICK[p][j]);
                    end
                end
            end
            for (int i = 0; i < 4; i++) begin
                if (lv[i]) begin
                    remembered_dir = arrow_dir(i);
                    return remembered_dir;
                end
            end
            remembered_dir = DIR_NONE;
            return DIR_NONE;
        endfunction

        function logic [3:0] pick_eight(logic [3:0] lv);
            for (int i = 0; i < 4; i++) begin
                if (lv[i]) begin
                    for (int j = 0; j < 3; j++) begin
                        if (lv[NEXT_PICK[i][j]]) return PAIR_CODE[i][NEXT_PICK[i][j]];
                    end
                    return arrow_dir(i);
                end
            end
            return DIR_NONE;
        endfunction

        // Accepted input word: update key memory and arrows, queue the result
        function void take_key(logic [8:0] code, logic down, logic fend);
            t_key_flags f;
            int         cnt;
            int         d;
            int         p;
            f   = '0;
            d   = (delay_reg < 2) ? 2 : int'(delay_reg);
            p   = (period_reg == 0) ? 1 : int'(period_reg);
            cnt = int'(key_mem[code][8:0]);
            f.held = down;
            f.trig = down && !key_mem[code][9];
            if (down) begin
                cnt++;
                if (cnt >= d + p) cnt = d;   // fold back, also catches stale large counts
                f.rep = (cnt == 1) || (cnt == d);
            end else begin
                cnt = 0;
            end
            key_mem[code] = {down, 9'(cnt)};
            for (int i = 0; i < 4; i++) begin
                if (code == arrow_code[i]) arrows_down[i] = down;
            end
            if (fend) begin
                four_now  = pick_four(arrows_down);
                eight_now = pick_eight(arrows_down);
            end
            f.four  = four_now;
            f.eight = eight_now;
            flags_due = {flags_due, f};
        endfunction

        function void compare(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        // Accepted result word: compare with the oldest prediction
        function void match_flags(logic [15:0] word);
            t_key_flags got;
            t_key_flags want;
            got = word[10:0];
            if (flags_due.size() == 0) begin
                $error("result word %h with nothing predicted", word);
                error_count++;
                return;
            end
            want = flags_due.pop_front();
            compare("held", 4'(want.held), 4'(got.held));
            compare("triggered", 4'(want.trig), 4'(got.trig));
            compare("repeated", 4'(want.rep), 4'(got.rep));
            compare("dir_four", want.four, got.four);
            compare("dir_eight", want.eight, got.eight);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [8:0]  i_cfg_wdata;

    t_key_tracker tracker;
    bit tx_calm = 1'b1;     // sender offers back to back
    bit rx_calm = 1'b1;     // receiver always ready
    int hold_off = 0;       // long receiver stall, picked up by the receiver

    key_autorepeat_and_direction_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Delay 0 and 1 behave as 2; keep most values small so repeats show up
    function automatic logic [7:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(2, 12));
        endcase
    endfunction

    // Period 0 behaves as 1
    function automatic logic [7:0] pick_period();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'($urandom_range(1, 8));
        endcase
    endfunction

    // Offer one key word and hold it until taken
    task automatic send_key(logic [8:0] code, logic down, logic fend);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, down, code};
        s_axis_tlast  <= fend;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_key(code, down, fend);
    endtask

    // Stop offering and wait for every predicted word, plus the pipe depth
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.flags_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the enable after the last one
    task automatic put_reg(t_cfg_idx idx, logic [8:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_config(logic [7:0] delay, logic [7:0] period,
                                logic [8:0] dn, logic [8:0] lf,
                                logic [8:0] rt, logic [8:0] up);
        put_reg(CFG_REPEAT_DELAY, {1'b0, delay});
        put_reg(CFG_REPEAT_PERIOD, {1'b0, period});
        put_reg(CFG_DOWN_KEY, dn);
        put_reg(CFG_LEFT_KEY, lf);
        put_reg(CFG_RIGHT_KEY, rt);
        put_reg(CFG_UP_KEY, up);
        i_cfg_we <= 1'b0;
    endtask

    // Random settings, then scan frames over a few hot keys whose levels
    // flip now and then, with stray keys and the odd frame with no end mark.
    task automatic run_phase(int count, int rx_hold);
        logic [8:0] arrows [4];
        logic [8:0] hot [6];
        logic       lvl [6];
        logic [9:0] frame [$];      // {level, scancode}
        int         sent;
        int         start;
        bit         broken;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0: arrows[k] = 9'd0;
                1: arrows[k] = 9'd511;
                2: arrows[k] = (k > 0) ? arrows[k-1] : 9'($urandom);  // shared binding
                default: arrows[k] = 9'($urandom);
            endcase
        end
        drain();
        apply_config(pick_delay(), pick_period(), arrows[0], arrows[1], arrows[2], arrows[3]);
        hold_off = rx_hold;
        for (int k = 0; k < 4; k++) hot[k] = arrows[k];
        hot[4] = 9'($urandom);
        hot[5] = 9'($urandom);
        for (int k = 0; k < 6; k++) lvl[k] = 1'b0;
        sent = 0;
        while (sent < count) begin
            frame.delete();
            start = $urandom_range(0, 5);
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 6) == 0) lvl[(k + start) % 6] = !lvl[(k + start) % 6];
                    frame = {frame, {lvl[(k + start) % 6], hot[(k + start) % 6]}};
                end
                if ($urandom_range(0, 19) == 0) frame = {frame, 10'($urandom)};
            end
            if (frame.size() == 0) frame = {frame, 10'($urandom)};
            broken = ($urandom_range(0, 15) == 0);
            foreach (frame[j]) begin
                send_key(frame[j][8:0], frame[j][9], (j == frame.size() - 1) && !broken);
            end
            sent += frame.size();
        end
    endtask

    // Receiver: take result words and stall at random
    initial begin
        int idle_left;
        idle_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                tracker.match_flags(m_axis_tdata);
            end
            if (hold_off > 0) begin
                idle_left = hold_off;
                hold_off  = 0;
            end else if (idle_left == 0 && !rx_calm) begin
                idle_left = pick_gap();
            end
            if (idle_left > 0) begin
                m_axis_tready <= 1'b0;
                idle_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        tracker = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_REPEAT_DELAY;
        i_cfg_wdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: code extremes, edge and first repeat, arrow walk
        // through memory, opposite pairs and holding between frame ends.
        send_key(9'd0, 1'b0, 1'b1);
        send_key(9'd511, 1'b1, 1'b0);
        send_key(9'd511, 1'b1, 1'b0);
        send_key(9'd511, 1'b0, 1'b1);
        send_key(RST_DOWN_KEY, 1'b1, 1'b1);
        send_key(RST_LEFT_KEY, 1'b1, 1'b1);
        send_key(RST_UP_KEY, 1'b1, 1'b1);
        send_key(RST_LEFT_KEY, 1'b0, 1'b0);
        send_key(9'd300, 1'b0, 1'b1);       // down and up alone
        send_key(RST_DOWN_KEY, 1'b0, 1'b1);
        send_key(RST_RIGHT_KEY, 1'b1, 1'b1);
        send_key(RST_LEFT_KEY, 1'b1, 1'b1);
        send_key(RST_UP_KEY, 1'b0, 1'b1);   // left and right alone
        send_key(RST_LEFT_KEY, 1'b0, 1'b0);
        send_key(RST_RIGHT_KEY, 1'b0, 1'b1);

        // Delay under two and zero period; one code on two arrows each
        drain();
        apply_config(8'd1, 8'd0, 9'd0, 9'd511, 9'd511, 9'd0);
        send_key(9'd0, 1'b1, 1'b1);
        send_key(9'd511, 1'b1, 1'b1);
        send_key(9'd0, 1'b0, 1'b1);
        repeat (4) send_key(9'd3, 1'b1, 1'b0);
        send_key(9'd3, 1'b0, 1'b1);

        // Longest fold: hold one key past 255+255, then shrink the window
        // so the stale count snaps back to the delay.
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain();
        apply_config(8'd255, 8'd255, RST_DOWN_KEY, RST_LEFT_KEY, RST_RIGHT_KEY, RST_UP_KEY);
        for (int n = 0; n < 520; n++) send_key(9'd5, 1'b1, (n % 8) == 7);
        drain();
        apply_config(8'd2, 8'd1, RST_DOWN_KEY, RST_LEFT_KEY, RST_RIGHT_KEY, RST_UP_KEY);
        repeat (3) send_key(9'd5, 1'b1, 1'b1);
        send_key(9'd5, 1'b0, 1'b1);

        // Random frames; one calm phase, one with a long receiver hold while
        // the sender keeps offering so the input stalls.
        for (int ph = 0; ph < 8; ph++) begin
            tx_calm = (ph == 3) || (ph == 5);
            rx_calm = (ph == 3);
            run_phase(20, (ph == 5) ? 80 : 0);
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule
